[design/rmf_pkg.sv]
package rmf_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } rmf_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_frame;
  } rmf_out_t;

endpackage

[design/rmf_ram.sv]
module rmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/rgb_median_filter_9x9.sv]
// Channel | Ports                            | Payload
// in      | in_valid, in_ready, in_data      | rmf_in_t
// out     | out_valid, out_ready, out_data   | rmf_out_t
// cfg     | cfg_valid, cfg_ready, cfg_index  | cfg_data (13 bit)
// Each word is handled in sequence: the sample is written to the line store, then the
// median is found bit by bit, one pass over the WINDOW*WINDOW taps per bit, reading one
// tap a cycle from the line store. No new word is taken until the engine is idle again.
// Reset is synchronous; the line store is not cleared. A stalled result holds the
// engine before the output load; in_ready is open when the engine is idle and cfg_valid is low.
module rgb_median_filter_9x9 import rmf_pkg::*; #(
  parameter int WINDOW     = 9,
  parameter int MAX_WIDTH  = 1024,
  parameter int COMPONENTS = 3,
  parameter int PIXEL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rmf_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [12:0]          cfg_data
);

  localparam int HALF    = WINDOW / 2;
  localparam int TAPS    = WINDOW * WINDOW;
  localparam int RANK    = TAPS / 2;
  localparam int DEPTH   = (WINDOW - 1) * MAX_WIDTH + WINDOW;
  localparam int AW      = $clog2(DEPTH);
  localparam int NC      = (COMPONENTS < 3) ? COMPONENTS : 3;
  localparam int SW      = NC * PIXEL_BITS;
  localparam int CW      = $clog2(MAX_WIDTH + 1);
  localparam int PW      = CW + 13;
  localparam int TW      = $clog2(TAPS + 1);
  localparam int BW      = $clog2(PIXEL_BITS + 1);
  localparam int DW      = $clog2(WINDOW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_OUT   = 3'd3;

  logic [10:0] width_reg_r;
  logic [12:0] height_reg_r;
  logic [CW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [CW-1:0] col_r;
  logic [12:0]   row_r;
  logic [PW-1:0] pos_r;
  logic [2:0]    state_r;

  logic [CW-1:0] qcol_r;
  logic [12:0]   qrow_r;
  logic [CW-1:0] ocol_r;
  logic [12:0]   orow_r;
  logic [PW-1:0] q_r;
  logic          eof_r;

  logic [DW-1:0] dr_r, dc_r;
  logic [TW-1:0] tap_r;
  logic          tap_ok_r;
  logic          rd_pend_r;
  logic [BW-1:0] bit_r;
  logic [TW-1:0] cnt_r [NC];
  logic [PIXEL_BITS-1:0] res_r [NC];
  logic          out_valid_r;
  rmf_out_t      out_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_data;
  logic [SW-1:0] tap_data;

  logic [PW-1:0] lat;
  logic [PW-1:0] frame_last;
  logic          in_fire;
  logic          in_image;

  always_comb begin
    w_eff = (width_reg_r == 11'd0) ? CW'(1) :
            (width_reg_r > 11'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_reg_r);
    h_eff = (height_reg_r == 13'd0) ? 13'd1 :
            (height_reg_r > 13'd4096) ? 13'd4096 : height_reg_r;
  end

  assign lat        = PW'(HALF) * PW'(w_eff) + PW'(HALF);
  assign frame_last = PW'(w_eff) * PW'(h_eff) - PW'(1);
  assign in_ready   = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_fire    = in_valid && in_ready;
  assign in_image   = !in_data.operation && (row_r < h_eff);

  // line store position: pos mod DEPTH, tracked with wrap
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] optr_r;

  assign wr_en   = in_fire;
  assign wr_addr = wptr_r;
  always_comb begin
    wr_data = '0;
    if (in_image) begin
      if (NC > 0) wr_data[PIXEL_BITS-1:0] = PIXEL_BITS'(in_data.in_red);
      if (NC > 1) wr_data[(NC > 1 ? 2 : 1)*PIXEL_BITS-1 -: PIXEL_BITS] =
        PIXEL_BITS'(in_data.in_green);
      if (NC > 2) wr_data[(NC > 2 ? 3 : 1)*PIXEL_BITS-1 -: PIXEL_BITS] =
        PIXEL_BITS'(in_data.in_blue);
    end
  end

  rmf_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // window tap address: opos + (dr-HALF)*w + (dc-HALF), modulo DEPTH
  logic signed [PW+1:0] r_s, c_s;
  logic                 tap_ok;
  logic [PW+1:0]        off;
  logic [PW+1:0]        addr_sum;
  logic [AW-1:0]        tap_addr;

  always_comb begin
    r_s = $signed({2'b00, PW'(orow_r)}) + $signed((PW+2)'(dr_r)) - (PW+2)'(HALF);
    c_s = $signed({2'b00, PW'(ocol_r)}) + $signed((PW+2)'(dc_r)) - (PW+2)'(HALF);
    tap_ok = (r_s >= 0) && (c_s >= 0) && (r_s < $signed((PW+2)'(h_eff))) &&
             (c_s < $signed((PW+2)'(w_eff)));
    off = (PW+2)'(dr_r) * (PW+2)'(w_eff) + (PW+2)'(dc_r);
    addr_sum = (PW+2)'(optr_r) + (PW+2)'(DEPTH) + off
             - (PW+2)'(HALF) * (PW+2)'(w_eff) - (PW+2)'(HALF);
    if (addr_sum >= (PW+2)'(2 * DEPTH)) addr_sum = addr_sum - (PW+2)'(2 * DEPTH);
    else if (addr_sum >= (PW+2)'(DEPTH)) addr_sum = addr_sum - (PW+2)'(DEPTH);
    tap_addr = AW'(addr_sum);
  end

  assign rd_addr  = tap_addr;
  assign tap_data = tap_ok_r ? rd_data : '0;

  logic [PIXEL_BITS-1:0] trial [NC];
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      trial[k] = res_r[k] | (PIXEL_BITS'(1) << bit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_reg_r  <= 11'd640;
      height_reg_r <= 13'd480;
      col_r        <= '0;
      row_r        <= '0;
      pos_r        <= '0;
      qcol_r       <= '0;
      qrow_r       <= '0;
      wptr_r       <= '0;
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_reg_r <= cfg_data[10:0];
        else height_reg_r <= cfg_data;
        col_r  <= '0;
        row_r  <= '0;
        pos_r  <= '0;
        qcol_r <= '0;
        qrow_r <= '0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (col_r + CW'(1) >= w_eff) begin
              col_r <= '0;
              row_r <= row_r + 13'd1;
            end else begin
              col_r <= col_r + CW'(1);
            end
            pos_r  <= pos_r + PW'(1);
            wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
            if (pos_r >= lat) begin
              q_r    <= pos_r - lat;
              ocol_r <= qcol_r;
              orow_r <= qrow_r;
              if (qcol_r + CW'(1) >= w_eff) begin
                qcol_r <= '0;
                qrow_r <= qrow_r + 13'd1;
              end else begin
                qcol_r <= qcol_r + CW'(1);
              end
              optr_r  <= wptr_r;
              state_r <= ST_ADDR;
            end
          end
        end
        ST_ADDR: begin
          optr_r <= (PW'(optr_r) >= lat) ? AW'(PW'(optr_r) - lat)
                                         : AW'(PW'(optr_r) + PW'(DEPTH) - lat);
          if (orow_r >= h_eff) begin
            col_r   <= '0;
            row_r   <= '0;
            pos_r   <= '0;
            qcol_r  <= '0;
            qrow_r  <= '0;
            state_r <= ST_IDLE;
          end else begin
            eof_r     <= (q_r == frame_last);
            dr_r      <= '0;
            dc_r      <= '0;
            tap_r     <= '0;
            rd_pend_r <= 1'b0;
            bit_r     <= BW'(PIXEL_BITS - 1);
            for (int k = 0; k < NC; k++) begin
              cnt_r[k] <= '0;
              res_r[k] <= '0;
            end
            state_r   <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (tap_r != TW'(TAPS)) begin
            tap_ok_r  <= tap_ok;
            rd_pend_r <= 1'b1;
            tap_r     <= tap_r + TW'(1);
            if (dc_r == DW'(WINDOW - 1)) begin
              dc_r <= '0;
              dr_r <= dr_r + DW'(1);
            end else begin
              dc_r <= dc_r + DW'(1);
            end
          end else begin
            rd_pend_r <= 1'b0;
          end
          if (rd_pend_r) begin
            for (int k = 0; k < NC; k++) begin
              if (tap_data[k*PIXEL_BITS +: PIXEL_BITS] < trial[k])
                cnt_r[k] <= cnt_r[k] + TW'(1);
            end
          end else if (tap_r == TW'(TAPS)) begin
            for (int k = 0; k < NC; k++) begin
              if (cnt_r[k] <= TW'(RANK)) res_r[k] <= trial[k];
              cnt_r[k] <= '0;
            end
            tap_r <= '0;
            dr_r  <= '0;
            dc_r  <= '0;
            if (bit_r == '0) state_r <= ST_OUT;
            else bit_r <= bit_r - BW'(1);
          end
        end
        ST_OUT: begin
          if (!out_valid_r) begin
            out_r.out_red      <= (NC > 0) ? 8'(res_r[0]) : 8'd0;
            out_r.out_green    <= (NC > 1) ? 8'(res_r[NC > 1 ? 1 : 0]) : 8'd0;
            out_r.out_blue     <= (NC > 2) ? 8'(res_r[NC > 2 ? 2 : 0]) : 8'd0;
            out_r.end_of_frame <= eof_r;
            out_valid_r        <= 1'b1;
            if (eof_r) begin
              col_r  <= '0;
              row_r  <= '0;
              pos_r  <= '0;
              qcol_r <= '0;
              qrow_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> (state_r == ST_IDLE))
    else $error("config during work");

endmodule
